### sv/pox_pkg.sv
// pox_pkg: shared types and constants of the pulse oximeter unit
// used by pulse_oximeter_spo2_and_rate_unit; no dependencies
package pox_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int COUNT_BITS_DEF  = 16;

    // register map
    localparam logic REG_PULSE_SCALE = 1'b0;
    localparam logic [15:0] PULSE_SCALE_RESET = 16'd30000;

    // spo2 map breakpoints and coefficients on the q8.8 ratio
    localparam logic [15:0] R_HIGH_LIMIT = 16'd102;
    localparam logic [15:0] R_LOW_LIMIT  = 16'd871;
    localparam logic [15:0] R_KNEE       = 16'd256;
    localparam logic [21:0] STEEP_OFFSET = 22'd3108352;
    localparam logic [11:0] STEEP_SLOPE  = 12'd3571;
    localparam logic [14:0] STEEP_DIV    = 15'd25600;
    localparam logic [14:0] SHALLOW_OFFSET = 15'd28160;
    localparam logic [4:0]  SHALLOW_SLOPE  = 5'd25;
    localparam logic [6:0]  SPO2_FULL    = 7'd100;
    localparam logic [6:0]  SPO2_NONE    = 7'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_START1,
        ST_DIV1,
        ST_MAP,
        ST_START2,
        ST_DIV2,
        ST_DONE
    } pox_state_t;

endpackage

### sv/pox_div.sv
// pox_div: restoring divider, one quotient bit per cycle
// stand-alone; a zero divisor yields an all-ones quotient when DW is at least NW
module pox_div #(
    parameter int NW = 16,
    parameter int DW = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          busy,
    output logic [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;

    // one restoring step
    always_comb begin
        shifted  = {rem_reg, quo_reg[NW-1]};
        diff     = shifted - {1'b0, den_reg};
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        quo_next = quo_reg;
        if (start) begin
            cnt_next = CW'(NW);
            rem_next = '0;
            den_next = den;
            quo_next = num;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = diff[DW] ? shifted[DW-1:0] : diff[DW-1:0];
            quo_next = {quo_reg[NW-2:0], ~diff[DW]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            quo_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            quo_reg <= quo_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = (cnt_reg != '0);
    assign quo  = quo_reg;

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy) else $error("divider not busy after start");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!busy && !start) |=> $stable(quo_reg)) else $error("quotient moved while idle");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(NW)) else $error("step count out of range");
endmodule

### sv/pulse_oximeter_spo2_and_rate_unit.sv
// pulse_oximeter_spo2_and_rate_unit: top level, peak tracking, sequencer and estimates
// depends on pox_pkg and pox_div
//
// One beat in gives one result beat out. An ordinary sample is accepted, then its
// result goes to the output register. A sample at a rising red zero crossing also runs the
// ratio and pulse divisions together on serial dividers, one quotient bit a cycle,
// then on the steep part of the spo2 curve a second division on the ratio divider.
// The next beat is taken once the result sits in the output register.
module pulse_oximeter_spo2_and_rate_unit #(
    parameter int SAMPLE_BITS = pox_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = pox_pkg::COUNT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // tdata: red_ac, red_dc, ir_ac, ir_dc (SAMPLE_BITS each), zero pad to bytes
    input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: pulse_rate[15:0], oxygen_saturation[22:16], zero bit 23
    output logic [23:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pox_pkg::*;

    localparam int S      = SAMPLE_BITS;
    localparam int NUM_W  = 2*S + 8;
    localparam int DEN_W  = 2*S;

    pox_state_t state_reg, state_next;

    logic [15:0] scale_reg;
    logic signed [S-1:0] prev_reg, prev_next;
    logic signed [S-1:0] rpk_reg, rpk_next, rtr_reg, rtr_next;
    logic signed [S-1:0] ipk_reg, ipk_next, itr_reg, itr_next;
    logic signed [S-1:0] ipk_base, itr_base;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next, pcnt_reg;
    logic [15:0] pulse_reg;
    logic [6:0]  sat_reg;
    logic [S-1:0] rpp_reg, ipp_reg, rdc_reg, idc_reg;
    logic [DEN_W-1:0] nprod_reg, dprod_reg;
    logic [15:0] r_reg;
    logic [21:0] steep_num_reg;
    logic [21:0] steep_prod;
    logic [14:0] shallow_val;
    logic [16:0] pulse_sum;
    logic        m_valid_reg;
    logic [23:0] m_data_reg;

    logic signed [S-1:0] rac, iac;
    logic [S-1:0] rdc, idc;
    logic accept, crossing, cfg_wr;

    logic rstart, pstart, rbusy, pbusy;
    logic [NUM_W-1:0] rnum, rquo;
    logic [DEN_W-1:0] rden;
    logic [15:0] pquo;

    // input unpacking
    assign rac = $signed(s_tdata[S-1:0]);
    assign rdc = s_tdata[2*S-1:S];
    assign iac = $signed(s_tdata[3*S-1:2*S]);
    assign idc = s_tdata[4*S-1:3*S];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign crossing = !rac[S-1] && prev_reg[S-1];

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_PULSE_SCALE);
    assign prdata = (paddr[2] == REG_PULSE_SCALE) ? {16'd0, scale_reg} : 32'd0;

    // peak, trough and sample count tracking
    always_comb begin
        prev_next = prev_reg;
        rpk_next  = rpk_reg;
        rtr_next  = rtr_reg;
        ipk_next  = ipk_reg;
        itr_next  = itr_reg;
        cnt_next  = cnt_reg;
        ipk_base  = crossing ? '0 : ipk_reg;
        itr_base  = crossing ? '0 : itr_reg;
        if (accept) begin
            prev_next = rac;
            if (crossing) begin
                rpk_next = '0;
                rtr_next = '0;
            end else if (rac > $signed(S'(0))) begin
                if (rac > rpk_reg) rpk_next = rac;
            end else begin
                if (rac < rtr_reg) rtr_next = rac;
            end
            ipk_next = ipk_base;
            itr_next = itr_base;
            if (iac > $signed(S'(0))) begin
                if (iac > ipk_base) ipk_next = iac;
            end else begin
                if (iac < itr_base) itr_next = iac;
            end
            if (crossing) begin
                cnt_next = COUNT_BITS'(1);
            end else if (cnt_reg != {COUNT_BITS{1'b1}}) begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = crossing ? ST_MUL : ST_DONE;
            ST_MUL:    state_next = ST_START1;
            ST_START1: state_next = ST_DIV1;
            ST_DIV1:   if (!rbusy && !pbusy) state_next = ST_MAP;
            ST_MAP: begin
                if (r_reg > R_KNEE && r_reg < R_LOW_LIMIT) state_next = ST_START2;
                else state_next = ST_DONE;
            end
            ST_START2: state_next = ST_DIV2;
            ST_DIV2:   if (!rbusy) state_next = ST_DONE;
            ST_DONE:   if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // divider controls
    always_comb begin
        rstart = 1'b0;
        pstart = 1'b0;
        rnum   = {nprod_reg, 8'd0};
        rden   = dprod_reg;
        unique case (state_reg)
            ST_START1: begin
                rstart = 1'b1;
                pstart = 1'b1;
            end
            ST_START2: begin
                rstart = 1'b1;
                rnum   = NUM_W'(steep_num_reg);
                rden   = DEN_W'(STEEP_DIV);
            end
            default: begin
                rstart = 1'b0;
            end
        endcase
    end

    assign steep_prod  = 22'(STEEP_SLOPE) * 22'(r_reg[9:0]);
    assign shallow_val = SHALLOW_OFFSET - 15'(SHALLOW_SLOPE) * 15'(r_reg[8:0]);
    assign pulse_sum   = {1'b0, pulse_reg} + {1'b0, pquo};

    pox_div #(.NW(NUM_W), .DW(DEN_W)) u_ratio_div (
        .aclk(aclk), .aresetn(aresetn), .start(rstart),
        .num(rnum), .den(rden), .busy(rbusy), .quo(rquo)
    );

    pox_div #(.NW(16), .DW(COUNT_BITS)) u_pulse_div (
        .aclk(aclk), .aresetn(aresetn), .start(pstart),
        .num(scale_reg), .den(pcnt_reg), .busy(pbusy), .quo(pquo)
    );

    // control and estimate registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            scale_reg   <= PULSE_SCALE_RESET;
            prev_reg    <= '0;
            rpk_reg     <= '0;
            rtr_reg     <= '0;
            ipk_reg     <= '0;
            itr_reg     <= '0;
            cnt_reg     <= '0;
            pulse_reg   <= '0;
            sat_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            prev_reg  <= prev_next;
            rpk_reg   <= rpk_next;
            rtr_reg   <= rtr_next;
            ipk_reg   <= ipk_next;
            itr_reg   <= itr_next;
            cnt_reg   <= cnt_next;
            if (cfg_wr) scale_reg <= pwdata[15:0];
            if (state_reg == ST_DIV1 && !rbusy && !pbusy) pulse_reg <= pulse_sum[16:1];
            if (state_reg == ST_MAP) begin
                if (r_reg <= R_HIGH_LIMIT) sat_reg <= SPO2_FULL;
                else if (r_reg >= R_LOW_LIMIT) sat_reg <= SPO2_NONE;
                else if (r_reg <= R_KNEE) sat_reg <= shallow_val[14:8];
            end
            if (state_reg == ST_DIV2 && !rbusy) sat_reg <= rquo[6:0];
            if (state_reg == ST_DONE && (!m_valid_reg || m_tready)) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            rpp_reg  <= S'(rpk_reg - rtr_reg);
            ipp_reg  <= S'(ipk_reg - itr_reg);
            rdc_reg  <= rdc;
            idc_reg  <= idc;
            pcnt_reg <= cnt_reg;
        end
        if (state_reg == ST_MUL) begin
            nprod_reg <= rpp_reg * idc_reg;
            dprod_reg <= ipp_reg * rdc_reg;
        end
        if (state_reg == ST_DIV1 && !rbusy) begin
            r_reg <= (|rquo[NUM_W-1:16]) ? 16'hFFFF : rquo[15:0];
        end
        if (state_reg == ST_MAP) steep_num_reg <= STEEP_OFFSET - steep_prod;
        if (state_reg == ST_DONE && (!m_valid_reg || m_tready)) begin
            m_data_reg <= {1'b0, sat_reg, pulse_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_leave_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg != ST_IDLE)) else $error("accepted beat left no work");
    a_sat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sat_reg <= SPO2_FULL) else $error("spo2 estimate above full scale");
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside the result state");
endmodule
